### hdl/ptss_pkg.sv
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types, codes and the half-step coil pattern for the pan/tilt
// half-step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptss_pkg;

   localparam int POS_BITS   = 16;
   localparam int COUNT_BITS = 16;
   localparam int LIMIT_BITS = 16;
   localparam int COIL_BITS  = 4;
   localparam int PHASE_BITS = 3;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [POS_BITS-1:0]   POS_RESET   = POS_BITS'(5000);
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(10000);

   typedef logic [POS_BITS-1:0]   pos_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [LIMIT_BITS-1:0] limit_type;
   typedef logic [COIL_BITS-1:0]  coil_type;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_MOVE = 2'd1,
      OP_STOP = 2'd2,
      OP_SET  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [0:0] {
      REG_PAN_LIMIT  = 1'b0,
      REG_TILT_LIMIT = 1'b1
   } reg_type;

   typedef struct packed {
      coil_type  pan_coils;
      coil_type  tilt_coils;
      pos_type   pan_now;
      pos_type   tilt_now;
      count_type steps_done;
      logic      moving;
   } result_type;

   function automatic coil_type half_step(input logic [PHASE_BITS-1:0] phase);
      coil_type pattern;
      case (phase)
         3'd0:    pattern = 4'h8;
         3'd1:    pattern = 4'hc;
         3'd2:    pattern = 4'h4;
         3'd3:    pattern = 4'h6;
         3'd4:    pattern = 4'h2;
         3'd5:    pattern = 4'h3;
         3'd6:    pattern = 4'h1;
         3'd7:    pattern = 4'h9;
         default: pattern = 4'h0;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

### hdl/ptss_csr.sv
// ----------------------------------------------------------------------------
// ptss_csr
// Configuration registers: pan and tilt limits behind a simple APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptss_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ptss_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [ptss_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [ptss_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready,
   output ptss_pkg::limit_type                       pan_limit,
   output ptss_pkg::limit_type                       tilt_limit
);
   import ptss_pkg::*;

   limit_type pan_limit_ff, pan_limit_in;
   limit_type tilt_limit_ff, tilt_limit_in;
   logic      write_en;
   reg_type   reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = reg_type'(csr_paddr[2]);

   always_comb begin
      pan_limit_in  = pan_limit_ff;
      tilt_limit_in = tilt_limit_ff;
      if (write_en) begin
         case (reg_sel)
            REG_PAN_LIMIT:  pan_limit_in  = csr_pwdata[LIMIT_BITS-1:0];
            REG_TILT_LIMIT: tilt_limit_in = csr_pwdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_limit_ff  <= LIMIT_RESET;
         tilt_limit_ff <= LIMIT_RESET;
      end else begin
         pan_limit_ff  <= pan_limit_in;
         tilt_limit_ff <= tilt_limit_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PAN_LIMIT:  csr_prdata = CSR_DATA_BITS'(pan_limit_ff);
         REG_TILT_LIMIT: csr_prdata = CSR_DATA_BITS'(tilt_limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign pan_limit  = pan_limit_ff;
   assign tilt_limit = tilt_limit_ff;

endmodule

`default_nettype wire

### hdl/ptss_core.sv
// ----------------------------------------------------------------------------
// ptss_core
// Axis state and the per-item update: tick, move, stop and set positions.
// ----------------------------------------------------------------------------
`default_nettype none

module ptss_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            operation,
   input  wire logic [1:0]            direction,
   input  wire logic [15:0]           move_steps,
   input  wire logic [15:0]           new_pan_position,
   input  wire logic [15:0]           new_tilt_position,
   input  ptss_pkg::limit_type        pan_limit,
   input  ptss_pkg::limit_type        tilt_limit,
   output ptss_pkg::result_type       result
);
   import ptss_pkg::*;

   pos_type   pan_pos_ff, pan_pos_in;
   pos_type   tilt_pos_ff, tilt_pos_in;
   count_type progress_ff, progress_in;
   count_type target_ff, target_in;
   dir_type   dir_ff, dir_in;
   logic      run_ff, run_in;
   logic      tick_en_ff, tick_en_in;
   coil_type  pan_drive_ff, pan_drive_in;
   coil_type  tilt_drive_ff, tilt_drive_in;

   logic [PHASE_BITS-1:0] phase_fwd;
   logic [PHASE_BITS-1:0] phase_rev;
   logic                  at_end;

   assign phase_fwd = progress_ff[PHASE_BITS-1:0];
   assign phase_rev = ~phase_fwd;

   always_comb begin
      case (dir_ff)
         DIR_UP:    at_end = (tilt_pos_ff >= tilt_limit);
         DIR_DOWN:  at_end = (tilt_pos_ff == '0);
         DIR_LEFT:  at_end = (pan_pos_ff == '0);
         DIR_RIGHT: at_end = (pan_pos_ff >= pan_limit);
         default:   at_end = 1'b1;
      endcase
   end

   always_comb begin
      pan_pos_in    = pan_pos_ff;
      tilt_pos_in   = tilt_pos_ff;
      progress_in   = progress_ff;
      target_in     = target_ff;
      dir_in        = dir_ff;
      run_in        = run_ff;
      tick_en_in    = tick_en_ff;
      pan_drive_in  = pan_drive_ff;
      tilt_drive_in = tilt_drive_ff;
      if (accept) begin
         case (op_type'(operation))
            OP_TICK: begin
               if (tick_en_ff) begin
                  if (progress_ff == target_ff || at_end) begin
                     run_in = 1'b0;
                  end else begin
                     progress_in = progress_ff + 1'b1;
                     case (dir_ff)
                        DIR_UP: begin
                           tilt_drive_in = half_step(phase_rev);
                           tilt_pos_in   = tilt_pos_ff + 1'b1;
                        end
                        DIR_DOWN: begin
                           tilt_drive_in = half_step(phase_fwd);
                           tilt_pos_in   = tilt_pos_ff - 1'b1;
                        end
                        DIR_LEFT: begin
                           pan_drive_in = half_step(phase_fwd);
                           pan_pos_in   = pan_pos_ff - 1'b1;
                        end
                        default: begin
                           pan_drive_in = half_step(phase_rev);
                           pan_pos_in   = pan_pos_ff + 1'b1;
                        end
                     endcase
                  end
               end
            end
            OP_MOVE: begin
               dir_in      = dir_type'(direction);
               progress_in = '0;
               target_in   = move_steps;
               run_in      = 1'b1;
               tick_en_in  = 1'b1;
            end
            OP_STOP: begin
               tick_en_in    = 1'b0;
               run_in        = 1'b0;
               pan_drive_in  = '0;
               tilt_drive_in = '0;
            end
            default: begin
               pan_pos_in  = POS_BITS'(new_pan_position);
               tilt_pos_in = POS_BITS'(new_tilt_position);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_pos_ff    <= POS_RESET;
         tilt_pos_ff   <= POS_RESET;
         progress_ff   <= '0;
         target_ff     <= '0;
         dir_ff        <= DIR_UP;
         run_ff        <= 1'b0;
         tick_en_ff    <= 1'b0;
         pan_drive_ff  <= '0;
         tilt_drive_ff <= '0;
      end else begin
         pan_pos_ff    <= pan_pos_in;
         tilt_pos_ff   <= tilt_pos_in;
         progress_ff   <= progress_in;
         target_ff     <= target_in;
         dir_ff        <= dir_in;
         run_ff        <= run_in;
         tick_en_ff    <= tick_en_in;
         pan_drive_ff  <= pan_drive_in;
         tilt_drive_ff <= tilt_drive_in;
      end
   end

   assign result.pan_coils  = pan_drive_in;
   assign result.tilt_coils = tilt_drive_in;
   assign result.pan_now    = pan_pos_in[15:0];
   assign result.tilt_now   = tilt_pos_in[15:0];
   assign result.steps_done = progress_in;
   assign result.moving     = run_in;

endmodule

`default_nettype wire

### hdl/ptss_rsp_reg.sv
// ----------------------------------------------------------------------------
// ptss_rsp_reg
// Result register: holds one item until the result channel takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptss_rsp_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  ptss_pkg::result_type       result,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic                       full_stall,
   output ptss_pkg::result_type       rsp_data
);
   import ptss_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign full_stall = valid_ff & rsp_stall;

   always_comb begin
      valid_in = valid_ff & rsp_stall;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### hdl/pan_tilt_half_step_sequencer.sv
// ----------------------------------------------------------------------------
// pan_tilt_half_step_sequencer
// Half-step coil sequencer for a pan and a tilt four-coil stepper.
// ----------------------------------------------------------------------------
// One item is taken per clock. Each item updates the axis state in the cycle
// it is accepted and its single result appears in the output register on the
// next cycle. req_stall is high only while a result waits in that register
// and rsp_stall holds it (and during reset), so throughput is one item per
// cycle whenever the result side keeps up. Limits are written over the csr_
// port at byte addresses 0 (pan) and 4 (tilt).
`default_nettype none

module pan_tilt_half_step_sequencer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_operation,
   input  wire logic [1:0]                           req_direction,
   input  wire logic [15:0]                          req_move_steps,
   input  wire logic [15:0]                          req_new_pan_position,
   input  wire logic [15:0]                          req_new_tilt_position,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [3:0]                                rsp_pan_coils,
   output logic [3:0]                                rsp_tilt_coils,
   output logic [15:0]                               rsp_pan_now,
   output logic [15:0]                               rsp_tilt_now,
   output logic [15:0]                               rsp_steps_done,
   output logic                                      rsp_moving,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ptss_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [ptss_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [ptss_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                      csr_pready
);
   import ptss_pkg::*;

   limit_type  pan_limit;
   limit_type  tilt_limit;
   logic       accept;
   logic       full_stall;
   result_type result;
   result_type rsp_data;

   assign req_stall = reset | full_stall;
   assign accept    = req_valid & ~req_stall;

   ptss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pan_limit   (pan_limit),
      .tilt_limit  (tilt_limit)
   );

   ptss_core u_core (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .operation         (req_operation),
      .direction         (req_direction),
      .move_steps        (req_move_steps),
      .new_pan_position  (req_new_pan_position),
      .new_tilt_position (req_new_tilt_position),
      .pan_limit         (pan_limit),
      .tilt_limit        (tilt_limit),
      .result            (result)
   );

   ptss_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .full_stall (full_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_pan_coils  = rsp_data.pan_coils;
   assign rsp_tilt_coils = rsp_data.tilt_coils;
   assign rsp_pan_now    = rsp_data.pan_now;
   assign rsp_tilt_now   = rsp_data.tilt_now;
   assign rsp_steps_done = rsp_data.steps_done;
   assign rsp_moving     = rsp_data.moving;

endmodule

`default_nettype wire

### hdl/ptss_checker.sv
// ----------------------------------------------------------------------------
// ptss_checker
// Port-level checks for the pan/tilt half-step sequencer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ptss_port_checks (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [3:0]  rsp_pan_coils,
   input  wire logic [3:0]  rsp_tilt_coils,
   input  wire logic [15:0] rsp_steps_done,
   input  wire logic        rsp_moving
);
   import ptss_pkg::*;

   logic accept;

   assign accept = req_valid & ~req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with no waiting result");

   a_stop_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_STOP |=>
         rsp_valid && !rsp_moving && rsp_pan_coils == '0 && rsp_tilt_coils == '0)
      else $error("stop item did not clear coils and run");

   a_move_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == OP_MOVE |=> rsp_valid && rsp_moving && rsp_steps_done == '0)
      else $error("move item did not start a run");

endmodule

bind pan_tilt_half_step_sequencer ptss_port_checks u_ptss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pan_coils  (rsp_pan_coils),
   .rsp_tilt_coils (rsp_tilt_coils),
   .rsp_steps_done (rsp_steps_done),
   .rsp_moving     (rsp_moving)
);

`default_nettype wire
